@@ rtl/core/sesq_pkg.sv @@
// ----------------------------------------------------------------------------
// sesq_pkg
// Shared types and constants for the SPI EEPROM access sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sesq_pkg;

    localparam int ADDR_W     = 24;
    localparam int ADDR_BITS  = 24;
    localparam int PAGE_BYTES = 256;
    localparam int PAGE_BITS  = $clog2(PAGE_BYTES);
    localparam int STREAM_W   = ADDR_W + 1;
    localparam int STEP_W     = 4;
    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 8;
    localparam int OUT_TUSER_W = 3;

    localparam logic [ADDR_W-1:0] ADDR_MASK =
        ADDR_W'((STREAM_W'(1) << ADDR_BITS) - STREAM_W'(1));

    localparam logic [7:0] CMD_READ  = 8'h03;
    localparam logic [7:0] CMD_WREN  = 8'h06;
    localparam logic [7:0] CMD_WRITE = 8'h02;

    // Entry points into the command sequences
    localparam logic [STEP_W-1:0] STEP_FIRST     = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_READ_RECV = STEP_W'(7);
    localparam logic [STEP_W-1:0] STEP_WR_DATA   = STEP_W'(11);

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_RX    = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ACT_DESELECT = 3'd0,
        ACT_SELECT   = 3'd1,
        ACT_WAIT     = 3'd2,
        ACT_SEND     = 3'd3,
        ACT_RECEIVE  = 3'd4,
        ACT_PROGRAM  = 3'd5,
        ACT_DATA     = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_DATA  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [STEP_W-1:0]   start;
        logic [ADDR_W-1:0]   addr;
        logic [7:0]          dbyte;
        logic                close;
    } job_t;

    typedef struct packed {
        logic full;
        logic valid;
    } q_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/sesq_front.sv @@
// ----------------------------------------------------------------------------
// sesq_front
// Accepts requests, tracks the read stream and write state, and issues jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module sesq_front (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [1:0]               op,
    input  wire logic [sesq_pkg::ADDR_W-1:0] address,
    input  wire logic [7:0]               data,
    input  wire logic                     last,
    input  wire sesq_pkg::q_stat_t        q_stat,
    output logic                          push,
    output sesq_pkg::job_t                job
);
    import sesq_pkg::*;

    logic [STREAM_W-1:0] sa_reg, sa_next;
    logic                sv_reg, sv_next;
    logic                wo_reg, wo_next;
    logic [7:0]          cached_reg, cached_next;

    logic                accept;
    logic [ADDR_W-1:0]   addr_m;
    logic [STREAM_W-1:0] addr_ext;
    logic [STREAM_W-1:0] addr_inc;
    logic [STREAM_W-1:0] wr_base;
    logic [STREAM_W-1:0] wr_inc;
    logic                sv_rd;
    logic                close;
    op_t                 op_c;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;
    assign op_c     = op_t'(op);
    assign addr_m   = address & ADDR_MASK;
    assign addr_ext = {1'b0, addr_m};
    assign addr_inc = addr_ext + STREAM_W'(1);
    assign wr_base  = wo_reg ? sa_reg : addr_ext;
    assign wr_inc   = wr_base + STREAM_W'(1);
    assign close    = last || (wr_inc[PAGE_BITS-1:0] == '0);
    // a read drops any open write and with it the stream
    assign sv_rd    = sv_reg && !wo_reg;

    always_comb
    begin
        sa_next     = sa_reg;
        sv_next     = sv_reg;
        wo_next     = wo_reg;
        cached_next = cached_reg;
        push        = 1'b0;
        job.kind    = KIND_DATA;
        job.start   = STEP_FIRST;
        job.addr    = addr_m;
        job.dbyte   = data;
        job.close   = 1'b0;
        if (accept)
        begin
            unique case (op_c)
                OP_READ:
                begin
                    push    = 1'b1;
                    wo_next = 1'b0;
                    sv_next = sv_rd;
                    if (sv_rd && (addr_inc == sa_reg))
                    begin
                        job.kind  = KIND_DATA;
                        job.dbyte = cached_reg;
                    end
                    else if (sv_rd && (addr_ext == sa_reg))
                    begin
                        job.kind  = KIND_READ;
                        job.start = STEP_READ_RECV;
                    end
                    else
                    begin
                        job.kind = KIND_READ;
                        sa_next  = addr_ext;
                        sv_next  = 1'b1;
                    end
                end
                OP_WRITE:
                begin
                    push      = 1'b1;
                    job.kind  = KIND_WRITE;
                    job.start = wo_reg ? STEP_WR_DATA : STEP_FIRST;
                    job.addr  = wr_base[ADDR_W-1:0];
                    job.close = close;
                    sa_next   = wr_inc;
                    wo_next   = !close;
                    sv_next   = wo_reg && sv_reg && !last;
                end
                OP_RX:
                begin
                    push        = 1'b1;
                    cached_next = data;
                    if (sv_reg)
                    begin
                        sa_next = sa_reg + STREAM_W'(1);
                    end
                end
                OP_NONE:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_reg     <= '0;
            sv_reg     <= 1'b0;
            wo_reg     <= 1'b0;
            cached_reg <= '0;
        end
        else
        begin
            sa_reg     <= sa_next;
            sv_reg     <= sv_next;
            wo_reg     <= wo_next;
            cached_reg <= cached_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/sesq_queue.sv @@
// ----------------------------------------------------------------------------
// sesq_queue
// Two-entry job queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module sesq_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire sesq_pkg::job_t wr_job,
    input  wire logic           rd_en,
    output sesq_pkg::job_t      rd_job,
    output sesq_pkg::q_stat_t   stat
);
    import sesq_pkg::*;

    job_t       mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_wr;
    logic       do_rd;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.valid = (count_reg != 2'd0);
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && stat.valid;
    assign rd_job     = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_wr;
        rd_ptr_next = rd_ptr_reg ^ do_rd;
        count_next  = count_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/sesq_back.sv @@
// ----------------------------------------------------------------------------
// sesq_back
// Expands each job into its SPI action sequence, one action per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module sesq_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sesq_pkg::q_stat_t q_stat,
    input  wire sesq_pkg::job_t    q_job,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output sesq_pkg::action_t      action,
    output logic [7:0]             value,
    output logic                   run_end
);
    import sesq_pkg::*;

    job_t              cur_reg;
    logic              cur_valid_reg, cur_valid_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_valid_reg, m_valid_next;
    action_t           m_act_reg;
    logic [7:0]        m_val_reg;
    logic              m_last_reg;

    action_t           d_act;
    logic [7:0]        d_val;
    logic              d_last;
    logic              out_free;
    logic              emit;

    // step decode; writes share one table, continuation writes enter at the data byte
    always_comb
    begin
        d_act  = ACT_DESELECT;
        d_val  = '0;
        d_last = 1'b0;
        unique case (cur_reg.kind)
            KIND_READ:
            begin
                unique case (step_reg)
                    4'd0: d_act = ACT_DESELECT;
                    4'd1: d_act = ACT_WAIT;
                    4'd2: d_act = ACT_SELECT;
                    4'd3: begin d_act = ACT_SEND; d_val = CMD_READ; end
                    4'd4: begin d_act = ACT_SEND; d_val = cur_reg.addr[23:16]; end
                    4'd5: begin d_act = ACT_SEND; d_val = cur_reg.addr[15:8]; end
                    4'd6: begin d_act = ACT_SEND; d_val = cur_reg.addr[7:0]; end
                    default:
                    begin
                        d_act  = ACT_RECEIVE;
                        d_last = 1'b1;
                    end
                endcase
            end
            KIND_WRITE:
            begin
                unique case (step_reg)
                    4'd0, 4'd4: d_act = ACT_DESELECT;
                    4'd1, 4'd5: d_act = ACT_WAIT;
                    4'd2, 4'd6: d_act = ACT_SELECT;
                    4'd3:  begin d_act = ACT_SEND; d_val = CMD_WREN; end
                    4'd7:  begin d_act = ACT_SEND; d_val = CMD_WRITE; end
                    4'd8:  begin d_act = ACT_SEND; d_val = cur_reg.addr[23:16]; end
                    4'd9:  begin d_act = ACT_SEND; d_val = cur_reg.addr[15:8]; end
                    4'd10: begin d_act = ACT_SEND; d_val = cur_reg.addr[7:0]; end
                    4'd11:
                    begin
                        d_act  = ACT_SEND;
                        d_val  = cur_reg.dbyte;
                        d_last = !cur_reg.close;
                    end
                    4'd12: d_act = ACT_DESELECT;
                    default:
                    begin
                        d_act  = ACT_PROGRAM;
                        d_last = 1'b1;
                    end
                endcase
            end
            default:
            begin
                d_act  = ACT_DATA;
                d_val  = cur_reg.dbyte;
                d_last = 1'b1;
            end
        endcase
    end

    assign out_free = !m_valid_reg || out_ready;
    assign emit     = cur_valid_reg && out_free;
    assign pop      = q_stat.valid && (!cur_valid_reg || (emit && d_last));

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        step_next      = step_reg;
        if (pop)
        begin
            cur_valid_next = 1'b1;
            step_next      = q_job.start;
        end
        else if (emit)
        begin
            cur_valid_next = !d_last;
            step_next      = step_reg + STEP_W'(1);
        end
        m_valid_next = emit || (m_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        if (pop)
        begin
            cur_reg <= q_job;
        end
        if (emit)
        begin
            m_act_reg  <= d_act;
            m_val_reg  <= d_val;
            m_last_reg <= d_last;
        end
    end

    assign out_valid = m_valid_reg;
    assign action    = m_act_reg;
    assign value     = m_val_reg;
    assign run_end   = m_last_reg;

endmodule

`default_nettype wire

@@ rtl/core/spi_eeprom_access_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// spi_eeprom_access_sequencer_unit
// Byte-level EEPROM read/write requests in, SPI bus actions out.
// ----------------------------------------------------------------------------
// The block emits one SPI action per clock while the output is not stalled.
// A request produces between one and fourteen actions (cached read, stream
// read and received byte: one; fresh read: eight; write byte: one, three,
// twelve or fourteen). The action expander works on one request at a time
// and, stepping through one sequence table entry per cycle unless the output
// stalls, sets the rate. Requests are classified and the stream/write state
// updated in the cycle they are accepted; a two-entry job queue lets the
// input side take up to two further requests while a sequence is still being
// played out, and an output register decouples the result stream. When the
// expander is idle the first action of a request passes through the job queue,
// the current-job register and the output register before it is offered.
`default_nettype none

module spi_eeprom_access_sequencer_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // address[23:0], data[31:24]
    input  wire logic [sesq_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // op[1:0]
    input  wire logic [sesq_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    input  wire logic                              s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // value[7:0]
    output logic [sesq_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // action[2:0]
    output logic [sesq_pkg::OUT_TUSER_W-1:0]       m_axis_tuser,
    output logic                                   m_axis_tlast
);
    import sesq_pkg::*;

    logic      push;
    job_t      f_job;
    job_t      q_job;
    q_stat_t   q_stat;
    logic      pop;
    action_t   action;
    logic [7:0] value;

    sesq_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .op       (s_axis_tuser),
        .address  (s_axis_tdata[23:0]),
        .data     (s_axis_tdata[31:24]),
        .last     (s_axis_tlast),
        .q_stat   (q_stat),
        .push     (push),
        .job      (f_job)
    );

    sesq_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (push),
        .wr_job (f_job),
        .rd_en  (pop),
        .rd_job (q_job),
        .stat   (q_stat)
    );

    sesq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_job     (q_job),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .action    (action),
        .value     (value),
        .run_end   (m_axis_tlast)
    );

    assign m_axis_tdata = value;
    assign m_axis_tuser = action;

`ifndef SYNTHESIS
    // input is only held off by a full job queue
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> q_stat.full)
        else $error("input stalled with queue space free");

    // returned data always closes its request
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (action == ACT_DATA)) |-> m_axis_tlast)
        else $error("read data not marked as run end");

    // a program wait always closes a write transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (action == ACT_PROGRAM)) |-> m_axis_tlast)
        else $error("program wait not marked as run end");

    // nothing is popped from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_stat.valid)
        else $error("pop from empty job queue");
`endif

endmodule

`default_nettype wire
